[rtl/core/mouse_delta_rational_scaler_top_defines.svh]
// Assertion macros shared by the mouse delta scaler RTL.
`ifndef MOUSE_DELTA_RATIONAL_SCALER_TOP_DEFINES_SVH
`define MOUSE_DELTA_RATIONAL_SCALER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MDRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define MDRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mdrs_pkg.sv]
// Shared types and constants for the mouse delta scaler.
`timescale 1ns / 1ps
package mdrs_pkg;

  localparam int OUT_W       = 20;  // scaled delta width
  localparam int BTN_W       = 5;   // button bits
  localparam int CFG_W       = 8;   // scale register width
  localparam int CFG_IDX_W   = 2;   // register index width
  localparam int REM_W       = 9;   // signed remainder width
  localparam int OUT_TDATA_W = ((2 * OUT_W + BTN_W + 7) / 8) * 8;
  localparam int MUL_STEPS   = CFG_W;  // one multiplier bit per cycle

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_MUL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_DIV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MUL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_DIV = 2'd3;

  // sequencer strobes to both axis lanes
  typedef struct packed {
    logic load;    // capture delta and multiplier
    logic mul_en;  // one shift-add step
    logic add_en;  // add remainder, take magnitude
    logic div_en;  // one restoring division step
    logic commit;  // result taken, remainder updated
  } lane_ctrl_t;

endpackage

[rtl/core/mdrs_axis.sv]
// One axis lane: serial multiply, remainder add, bit-serial restoring divide.
`timescale 1ns / 1ps
module mdrs_axis #(
  parameter int DELTA_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mdrs_pkg::lane_ctrl_t                ctrl_i,
  input  logic                                clear_i,
  input  logic signed [DELTA_BITS-1:0]        delta_i,
  input  logic [mdrs_pkg::CFG_W-1:0]          mul_i,
  input  logic [mdrs_pkg::CFG_W-1:0]          div_i,
  output logic [mdrs_pkg::OUT_W-1:0]          q_o
);
  import mdrs_pkg::*;

  localparam int W = DELTA_BITS + CFG_W + 1;  // signed dividend width
  localparam int N = W - 1;                   // magnitude / quotient width

  logic signed [W-1:0]     md_q, md_d;
  logic [CFG_W-1:0]        m_q, m_d;
  logic signed [W-1:0]     acc_q, acc_d;
  logic [N-1:0]            dv_q, dv_d;
  logic [CFG_W-1:0]        pr_q, pr_d;
  logic                    neg_q, neg_d;
  logic signed [REM_W-1:0] rem_q, rem_d;

  logic signed [W-1:0] t;
  logic [W-1:0]        t_mag;
  logic [CFG_W:0]      sh, diff, dvs;
  logic                ge;
  logic [REM_W-1:0]    rem_mag;
  logic [OUT_W-1:0]    q_mag;

  always_comb begin
    t       = acc_q + {{(W-REM_W){rem_q[REM_W-1]}}, rem_q};
    t_mag   = t[W-1] ? (~t + W'(1)) : t;
    dvs     = {1'b0, div_i};
    sh      = {pr_q, dv_q[N-1]};
    ge      = (sh >= dvs);
    diff    = sh - dvs;
    rem_mag = {1'b0, pr_q};
    q_mag   = OUT_W'(dv_q);
  end

  always_comb begin
    md_d  = md_q;
    m_d   = m_q;
    acc_d = acc_q;
    dv_d  = dv_q;
    pr_d  = pr_q;
    neg_d = neg_q;
    rem_d = rem_q;
    if (ctrl_i.load) begin
      md_d  = {{(W-DELTA_BITS){delta_i[DELTA_BITS-1]}}, delta_i};
      m_d   = mul_i;
      acc_d = '0;
    end
    if (ctrl_i.mul_en) begin
      if (m_q[0]) begin
        acc_d = acc_q + md_q;
      end
      md_d = md_q <<< 1;
      m_d  = m_q >> 1;
    end
    if (ctrl_i.add_en) begin
      neg_d = t[W-1];
      dv_d  = t_mag[N-1:0];
      pr_d  = '0;
    end
    if (ctrl_i.div_en) begin
      pr_d = ge ? diff[CFG_W-1:0] : sh[CFG_W-1:0];
      dv_d = {dv_q[N-2:0], ge};
    end
    if (ctrl_i.commit) begin
      rem_d = neg_q ? (~rem_mag + REM_W'(1)) : rem_mag;
    end
    if (clear_i) begin
      rem_d = '0;
    end
  end

  // carried remainder is architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    md_q  <= md_d;
    m_q   <= m_d;
    acc_q <= acc_d;
    dv_q  <= dv_d;
    pr_q  <= pr_d;
    neg_q <= neg_d;
  end

  assign q_o = neg_q ? (~q_mag + OUT_W'(1)) : q_mag;

endmodule

[rtl/core/mdrs_ctrl.sv]
// Sequencer: multiply steps, remainder add, divide steps, result hand-off.
`timescale 1ns / 1ps
`include "mouse_delta_rational_scaler_top_defines.svh"
module mdrs_ctrl #(
  parameter int DELTA_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_free_i,
  output logic                 in_ready_o,
  output mdrs_pkg::lane_ctrl_t ctrl_o
);
  import mdrs_pkg::*;

  localparam int DIV_STEPS = DELTA_BITS + CFG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    ctrl_o        = '0;
    ctrl_o.load   = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_MUL;
          cnt_d   = CNT_W'(MUL_STEPS - 1);
        end
      end
      S_MUL: begin
        ctrl_o.mul_en = 1'b1;
        cnt_d         = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        ctrl_o.add_en = 1'b1;
        state_d       = S_DIV;
        cnt_d         = CNT_W'(DIV_STEPS - 1);
      end
      S_DIV: begin
        ctrl_o.div_en = 1'b1;
        cnt_d         = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // hold here until the output register can take the result
        if (out_free_i) begin
          ctrl_o.commit = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `MDRS_ASSERT_NEXT(a_commit_to_idle, ctrl_o.commit, state_q == S_IDLE, "commit did not return to idle")
  `MDRS_ASSERT_NEXT(a_mul_then_add, ctrl_o.mul_en && (cnt_q == '0), ctrl_o.add_en, "multiply did not end in add step")
  `MDRS_ASSERT_NEXT(a_add_then_div, ctrl_o.add_en, ctrl_o.div_en, "add step not followed by divide")

endmodule

[rtl/core/mouse_delta_rational_scaler_top.sv]
// Top level of the mouse delta scaler: config registers, two axis lanes, output register.
// Usage:
//   Input stream s_axis carries one motion event per request: delta_x, delta_y and
//   buttons packed in s_axis_tdata. Output stream m_axis returns exactly one scaled
//   event per request: out_delta_x, out_delta_y and out_buttons in m_axis_tdata.
//   Each axis computes t = multiplier * delta + remainder, divides by the divisor with
//   truncation toward zero, and keeps t - divisor * quotient for the next event.
// Timing:
//   Both axes run in parallel. Each does 8 shift-add multiply steps (one multiplier bit
//   per cycle), 1 remainder add step and DELTA_BITS+8 restoring divide steps (one
//   quotient bit per cycle, 20 at the default), then a hand-off step that waits until
//   the output register can take the result. s_axis_tready is high only while the
//   sequencer is idle, so a new event is accepted only after the last is handed off.
// Stall: a finished result sits in the output register; the next event is accepted
//   and computed meanwhile, and its hand-off waits until the register is taken.
// Reset: rst_ni (async, active low) sets all scale registers to 1, clears both
//   remainders and empties the output register. Any config write clears both
//   remainders; a zero divisor write is held at 1. Write config only while idle.
`timescale 1ns / 1ps
`include "mouse_delta_rational_scaler_top_defines.svh"
module mouse_delta_rational_scaler_top #(
  parameter int DELTA_BITS = 12,
  localparam int InW = ((2 * DELTA_BITS + mdrs_pkg::BTN_W + 7) / 8) * 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write port
  input  logic                                 cfg_we_i,
  input  logic [mdrs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mdrs_pkg::CFG_W-1:0]           cfg_data_i,
  // input events
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [InW-1:0]                       s_axis_tdata,   // delta_x, delta_y, buttons
  // scaled events
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mdrs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata    // out_delta_x, out_delta_y,
                                                               // out_buttons
);
  import mdrs_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - 2 * OUT_W - BTN_W;

  logic [CFG_W-1:0] x_mul_q, x_div_q, y_mul_q, y_div_q;
  logic [CFG_W-1:0] cfg_div;
  logic             accept;
  logic             out_free;
  lane_ctrl_t       lane_ctrl;
  logic [BTN_W-1:0] btn_q, btn_d;
  logic [OUT_W-1:0] qx, qy;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // divisor writes of zero are held at one
  assign cfg_div = (cfg_data_i == '0) ? CFG_W'(1) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_mul_q <= CFG_W'(1);
      x_div_q <= CFG_W'(1);
      y_mul_q <= CFG_W'(1);
      y_div_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_MUL: x_mul_q <= cfg_data_i;
        REG_X_DIV: x_div_q <= cfg_div;
        REG_Y_MUL: y_mul_q <= cfg_data_i;
        REG_Y_DIV: y_div_q <= cfg_div;
        default:   x_mul_q <= x_mul_q;
      endcase
    end
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  mdrs_ctrl #(
    .DELTA_BITS (DELTA_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (lane_ctrl)
  );

  mdrs_axis #(
    .DELTA_BITS (DELTA_BITS)
  ) u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .clear_i (cfg_we_i),
    .delta_i (s_axis_tdata[DELTA_BITS-1:0]),
    .mul_i   (x_mul_q),
    .div_i   (x_div_q),
    .q_o     (qx)
  );

  mdrs_axis #(
    .DELTA_BITS (DELTA_BITS)
  ) u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .clear_i (cfg_we_i),
    .delta_i (s_axis_tdata[2*DELTA_BITS-1:DELTA_BITS]),
    .mul_i   (y_mul_q),
    .div_i   (y_div_q),
    .q_o     (qy)
  );

  // buttons ride alongside the computation
  assign btn_d = accept ? s_axis_tdata[2*DELTA_BITS+BTN_W-1:2*DELTA_BITS] : btn_q;

  always_ff @(posedge clk_i) begin
    btn_q <= btn_d;
  end

  // output register: loaded on commit, emptied when taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (lane_ctrl.commit) begin
      out_valid_d = 1'b1;
      out_data_d  = {{PAD_W{1'b0}}, btn_q, qy, qx};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `MDRS_ASSERT_NOW(a_commit_slot_free, lane_ctrl.commit, !out_valid_q || m_axis_tready, "commit overwrote a pending result")
  `MDRS_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready, "ready stayed high after accept")
  `MDRS_ASSERT_NEXT(a_x_div_nonzero, cfg_we_i && (cfg_idx_i == REG_X_DIV), x_div_q != '0, "x divisor became zero")

endmodule

[tb/mouse_delta_rational_scaler_top_tb.sv]
// Self-checking stream testbench for the mouse delta rational scaler top level.
`timescale 1ns / 1ps
module mouse_delta_rational_scaler_top_tb;
  import mdrs_pkg::*;

  localparam int DELTA_W      = 12;
  localparam int IN_W         = ((2 * DELTA_W + BTN_W + 7) / 8) * 8;
  localparam int PHASES       = 8;     // random phases, each with new scale settings
  localparam int PHASE_EVENTS = 210;
  localparam int QUIET_PHASE  = 2;     // phase run with no idling on either side
  localparam int STALL_AT     = 300;   // scaled events seen before the long receiver hold
  localparam int STALL_LEN    = 600;
  localparam int IDLE_LIMIT   = 4000;  // cycles with no request moved
  localparam int DRAIN_CYCLES = DELTA_W + 28;  // drain time after the last request, with margin
  localparam int MAX_REPORTS  = 10;

  // one row of the directed plan: either a register write or a motion event
  typedef struct {
    bit                        is_cfg;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_W-1:0]          val;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [BTN_W-1:0]          btn;
    bit                        typed;  // expected deltas given in the row
    logic signed [OUT_W-1:0]   ex;
    logic signed [OUT_W-1:0]   ey;
  } plan_row_t;

  typedef struct packed {
    logic [OUT_W-1:0] dx;
    logic [OUT_W-1:0] dy;
    logic [BTN_W-1:0] btn;
  } scaled_evt_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = REG_X_MUL;
  logic [CFG_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata  = '0;  // delta_x, delta_y, buttons
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // out_delta_x, out_delta_y, out_buttons

  // mirror of the scale registers and the carried remainders
  logic [CFG_W-1:0] mul_x = 8'd1;
  logic [CFG_W-1:0] div_x = 8'd1;
  logic [CFG_W-1:0] mul_y = 8'd1;
  logic [CFG_W-1:0] div_y = 8'd1;
  longint           carry_x = 0;
  longint           carry_y = 0;

  scaled_evt_t scaled_q[$];   // expected scaled events, oldest first
  plan_row_t   plan_q[$];

  int  events_sent   = 0;
  int  events_scaled = 0;
  int  cfg_writes    = 0;
  int  err_cnt       = 0;
  int  idle_cycles   = 0;
  int  stall_left    = 0;
  bit  stall_done    = 1'b0;
  bit  quiet         = 1'b0;

  mouse_delta_rational_scaler_top #(
    .DELTA_BITS(DELTA_W)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: t = mul * delta + carry, quotient truncated toward zero,
  // carry keeps t - div * quotient (same sign as t). SV division matches.
  // ---------------------------------------------------------------------------
  task automatic scale_axis(input logic signed [DELTA_W-1:0] d, input logic [CFG_W-1:0] m,
                            input logic [CFG_W-1:0] dv, inout longint carry,
                            output logic [OUT_W-1:0] q);
    longint mul_l, d_l, dv_l, t, quo;
    mul_l = m;     // zero extend
    d_l   = d;     // sign extend
    dv_l  = dv;
    t     = mul_l * d_l + carry;
    quo   = t / dv_l;
    carry = t - quo * dv_l;
    q     = quo[OUT_W-1:0];
  endtask

  task automatic note_failure(input string what);
    if (err_cnt < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, what);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Register write, with the mirror updated at the same time. Any write
  // clears both carries; a zero divisor is held at one.
  // Caller drops cfg_we_i after the last write of a group.
  // ---------------------------------------------------------------------------
  task automatic write_scale(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_X_MUL: mul_x = val;
      REG_X_DIV: div_x = (val == '0) ? 8'd1 : val;
      REG_Y_MUL: mul_y = val;
      REG_Y_DIV: div_y = (val == '0) ? 8'd1 : val;
      default: ;
    endcase
    carry_x = 0;
    carry_y = 0;
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // Stop offering, wait for every expected event, then let the block go idle.
  task automatic settle(input int extra);
    s_axis_tvalid <= 1'b0;
    while (scaled_q.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: random idle gaps, then hold the request until it is taken.
  // Entered and left at a falling edge; tvalid is assigned once per step.
  // ---------------------------------------------------------------------------
  task automatic offer_motion(input logic signed [DELTA_W-1:0] dx,
                              input logic signed [DELTA_W-1:0] dy,
                              input logic [BTN_W-1:0] btn, input bit typed,
                              input logic signed [OUT_W-1:0] ex,
                              input logic signed [OUT_W-1:0] ey);
    logic [IN_W-1:0] word;
    scaled_evt_t     want;
    while (!quiet && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    word = '0;
    word[DELTA_W-1:0]                         = dx;
    word[2*DELTA_W-1:DELTA_W]                 = dy;
    word[2*DELTA_W+BTN_W-1:2*DELTA_W]         = btn;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    // accepted: run the predictor even for typed rows to keep carries in step
    scale_axis(dx, mul_x, div_x, carry_x, want.dx);
    scale_axis(dy, mul_y, div_y, carry_y, want.dy);
    want.btn = btn;
    if (typed) begin
      want.dx = ex;
      want.dy = ey;
    end
    scaled_q.push_back(want);
    events_sent++;
    @(negedge clk_i);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    plan_q.push_back(r);
  endtask

  task automatic add_evt(input logic signed [DELTA_W-1:0] dx,
                         input logic signed [DELTA_W-1:0] dy,
                         input logic [BTN_W-1:0] btn, input bit typed,
                         input logic signed [OUT_W-1:0] ex, input logic signed [OUT_W-1:0] ey);
    plan_row_t r;
    r = '{default: '0};
    r.dx    = dx;
    r.dy    = dy;
    r.btn   = btn;
    r.typed = typed;
    r.ex    = ex;
    r.ey    = ey;
    plan_q.push_back(r);
  endtask

  // deltas: extremes, small values that stress carry, and full range
  function automatic logic signed [DELTA_W-1:0] pick_delta();
    case ($urandom_range(9))
      0, 1: begin
        case ($urandom_range(4))
          0:       return -2048;
          1:       return 2047;
          2:       return -1;
          3:       return 1;
          default: return 0;
        endcase
      end
      2, 3, 4, 5: return DELTA_W'(int'($urandom_range(30)) - 15);
      default:    return DELTA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_scale();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, none in the quiet phase, and one long hold once
  // enough events are through so the block fills up and drops s_axis_tready.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!stall_done && events_scaled >= STALL_AT) begin
      stall_left = STALL_LEN;
      stall_done = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 8);
    end
  end

  // Checker: each taken result against the oldest expectation.
  always @(posedge clk_i) begin
    scaled_evt_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.dx  = m_axis_tdata[OUT_W-1:0];
      got.dy  = m_axis_tdata[2*OUT_W-1:OUT_W];
      got.btn = m_axis_tdata[2*OUT_W+BTN_W-1:2*OUT_W];
      if (scaled_q.size() == 0) begin
        note_failure($sformatf("unexpected result dx=%0d dy=%0d btn=%h",
                               $signed(got.dx), $signed(got.dy), got.btn));
      end else begin
        want = scaled_q.pop_front();
        if (got != want)
          note_failure($sformatf(
            "event %0d: expected dx=%0d dy=%0d btn=%h, got dx=%0d dy=%0d btn=%h",
            events_scaled, $signed(want.dx), $signed(want.dy), want.btn,
            $signed(got.dx), $signed(got.dy), got.btn));
      end
      events_scaled++;
    end
  end

  // Watchdog: too long with no request moving on any port.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, scaled_q.size());
      $display("** mouse_delta_rational_scaler_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    plan_row_t row;
    int        n;

    // Directed plan. Reset scale is 1/1, so outputs equal inputs.
    add_evt(0, 0, 5'h00, 1, 0, 0);
    add_evt(2047, -2048, 5'h1f, 1, 2047, -2048);
    add_evt(-2048, 2047, 5'h00, 1, -2048, 2047);
    add_evt(-1, 1, 5'h15, 1, -1, 1);
    add_evt(1, -1, 5'h0a, 1, 1, -1);
    // zero multiplier on X
    add_cfg(REG_X_MUL, 8'd0);
    add_evt(2047, -300, 5'h01, 1, 0, -300);
    add_evt(-2048, 5, 5'h02, 1, 0, 5);
    // largest X gain; zero divisor write is held at one
    add_cfg(REG_X_MUL, 8'd255);
    add_cfg(REG_X_DIV, 8'd0);
    add_evt(-2048, 0, 5'h04, 1, -522240, 0);
    add_evt(2047, 0, 5'h08, 1, 521985, 0);
    // 255/255 on Y passes deltas through with no carry
    add_cfg(REG_Y_MUL, 8'd255);
    add_cfg(REG_Y_DIV, 8'd255);
    add_evt(0, -2048, 5'h10, 1, 0, -2048);
    add_evt(0, 2047, 5'h03, 1, 0, 2047);
    // fractional scales: carry builds up across events, both signs
    add_cfg(REG_X_MUL, 8'd1);
    add_cfg(REG_X_DIV, 8'd3);
    add_cfg(REG_Y_MUL, 8'd2);
    add_cfg(REG_Y_DIV, 8'd255);
    add_evt(1, 100, 5'h11, 0, 0, 0);
    add_evt(1, 100, 5'h12, 0, 0, 0);
    add_evt(1, 100, 5'h13, 0, 0, 0);
    add_evt(-1, -100, 5'h14, 0, 0, 0);
    add_evt(-1, -100, 5'h16, 0, 0, 0);
    add_evt(-7, -300, 5'h17, 0, 0, 0);
    add_evt(2, 127, 5'h18, 0, 0, 0);
    // zero Y divisor held at one; the write also clears both carries
    add_cfg(REG_Y_DIV, 8'd0);
    add_evt(7, -2048, 5'h19, 1, 2, -4096);
    // largest divisor: carry of 254 then rollover to one
    add_cfg(REG_X_DIV, 8'd255);
    add_evt(254, 3, 5'h1a, 0, 0, 0);
    add_evt(1, -3, 5'h1b, 0, 0, 0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the plan; register writes only once the block has drained.
    for (int i = 0; i < plan_q.size(); i++) begin
      row = plan_q[i];
      if (row.is_cfg) begin
        if (!cfg_we_i) settle(4);
        write_scale(row.idx, row.val);
      end else begin
        cfg_we_i <= 1'b0;
        offer_motion(row.dx, row.dy, row.btn, row.typed, row.ex, row.ey);
      end
    end

    // Random phases, each starting from one to four fresh register writes.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle(4);
      quiet = (ph == QUIET_PHASE);
      n = $urandom_range(1, 4);
      repeat (n) write_scale(CFG_IDX_W'($urandom_range(3)), pick_scale());
      cfg_we_i <= 1'b0;
      repeat (PHASE_EVENTS)
        offer_motion(pick_delta(), pick_delta(), BTN_W'($urandom), 1'b0, '0, '0);
    end
    quiet = 1'b0;

    settle(DRAIN_CYCLES);
    if (scaled_q.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", scaled_q.size()));

    $display("Covered %0d motion events under %0d scale register writes",
             events_sent, cfg_writes);
    $display("(directed extremes, then random); checked %0d scaled events",
             events_scaled);
    $display("through a %0d-cycle receiver hold; %0d errors.", STALL_LEN, err_cnt);
    if (err_cnt == 0) begin
      $display("** mouse_delta_rational_scaler_top: PASSED **");
    end else begin
      $display("** mouse_delta_rational_scaler_top: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/mdrs_pkg.sv
rtl/core/mdrs_axis.sv
rtl/core/mdrs_ctrl.sv
rtl/core/mouse_delta_rational_scaler_top.sv
tb/mouse_delta_rational_scaler_top_tb.sv
